// ===== src/bmp_stream_to_framebuffer_blit_macros.svh =====
// Assertion macros used by the blit top level.
`ifndef BMP_STREAM_TO_FRAMEBUFFER_BLIT_MACROS_SVH
`define BMP_STREAM_TO_FRAMEBUFFER_BLIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSFB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blit assertion failed");

// Next-cycle implication, disabled during reset.
`define BSFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blit assertion failed");

`endif

// ===== src/bsfb_pkg.sv =====
// Shared types and constants of the BMP framebuffer blit.
`timescale 1ns / 1ps
package bsfb_pkg;

  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 480;
  localparam int SCREEN_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET     = 8'd3;

  localparam int QUEUE_DEPTH = 2;

  // One classified word: either a finished pixel with its screen position
  // (two's complement, 15 bits) or a byte that yields an empty result.
  typedef struct packed {
    logic        pixel;
    logic [23:0] color;
    logic [14:0] sx;
    logic [14:0] sy;
    logic        done;
  } entry_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } queue_stat_t;

endpackage

// ===== src/bsfb_front.sv =====
// Front end: configuration registers, byte assembly, padding skip and counters.
`timescale 1ns / 1ps
module bsfb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bsfb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      pixel_byte,
  input  bsfb_pkg::queue_stat_t           q_stat,
  output logic                            push,
  output bsfb_pkg::entry_t                push_entry
);
  import bsfb_pkg::*;

  logic [11:0] image_width;
  logic [11:0] image_height;
  logic [12:0] x_offset;
  logic [12:0] y_offset;

  logic [1:0]  byte_phase;
  logic [7:0]  blue_hold;
  logic [7:0]  green_hold;
  logic [11:0] column_count;
  logic [11:0] row_count;
  logic [1:0]  pad_remaining;

  logic        row_end;
  logic        last_row;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_stat.full;
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd800;
      image_height <= 12'd480;
      x_offset     <= '0;
      y_offset     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[11:0];
        REG_X_OFFSET:     x_offset     <= cfg_data;
        REG_Y_OFFSET:     y_offset     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign row_end  = ({1'b0, column_count} + 13'd1) >= {1'b0, image_width};
  assign last_row = ({1'b0, row_count} + 13'd1) >= {1'b0, image_height};

  always_comb begin
    push_entry       = '0;
    push_entry.color = {pixel_byte, green_hold, blue_hold};
    push_entry.sx    = {3'b000, column_count} + {{2{x_offset[12]}}, x_offset};
    push_entry.sy    = {3'b000, image_height} - 15'd1 - {3'b000, row_count}
                       + {{2{y_offset[12]}}, y_offset};
    push_entry.done  = row_end && last_row;
    push_entry.pixel = (pad_remaining == 2'd0) && (byte_phase == 2'd2);
    if (!push_entry.pixel) begin
      push_entry.color = '0;
      push_entry.done  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= '0;
      blue_hold     <= '0;
      green_hold    <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_remaining <= '0;
    end else if (push) begin
      if (pad_remaining != 2'd0) begin
        pad_remaining <= pad_remaining - 2'd1;
      end else if (byte_phase == 2'd1) begin
        green_hold <= pixel_byte;
        byte_phase <= 2'd2;
      end else if (byte_phase == 2'd2) begin
        byte_phase <= 2'd0;
        if (row_end) begin
          column_count  <= '0;
          // Three bytes per pixel pad each row by width mod four bytes.
          pad_remaining <= image_width[1:0];
          if (last_row) begin
            row_count <= '0;
          end else begin
            row_count <= row_count + 12'd1;
          end
        end else begin
          column_count <= column_count + 12'd1;
        end
      end else begin
        blue_hold  <= pixel_byte;
        byte_phase <= 2'd1;
      end
    end
  end

endmodule

// ===== src/bsfb_queue.sv =====
// Two-entry queue between the front end and the write stage.
`timescale 1ns / 1ps
module bsfb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bsfb_pkg::entry_t      push_entry,
  input  logic                  pop,
  output bsfb_pkg::entry_t      pop_entry,
  output bsfb_pkg::queue_stat_t stat
);
  import bsfb_pkg::*;

  entry_t     slots [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign pop_entry  = slots[rd_ptr];
  assign stat.count = count;
  assign stat.full  = count == 2'(QUEUE_DEPTH);
  assign stat.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/bsfb_back.sv =====
// Write stage: screen clipping, framebuffer index and the output register.
`timescale 1ns / 1ps
module bsfb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  bsfb_pkg::queue_stat_t q_stat,
  input  bsfb_pkg::entry_t      pop_entry,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  write_valid,
  output logic [18:0]           write_index,
  output logic [23:0]           pixel_color,
  output logic                  image_done
);
  import bsfb_pkg::*;

  logic        on_screen;
  logic [18:0] index_calc;

  assign pop = !q_stat.empty && (!out_valid || out_ready);

  assign on_screen = pop_entry.pixel
                     && !pop_entry.sx[14] && (pop_entry.sx[13:0] < 14'(SCREEN_WIDTH))
                     && !pop_entry.sy[14] && (pop_entry.sy[13:0] < 14'(SCREEN_HEIGHT));

  // Only the low bits matter once the position is known to be on screen.
  assign index_calc = 19'(pop_entry.sy[8:0]) * 19'(SCREEN_WIDTH)
                      + 19'(pop_entry.sx[9:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      write_valid <= on_screen;
      write_index <= on_screen ? index_calc : '0;
      pixel_color <= pop_entry.color;
      image_done  <= pop_entry.done;
    end
  end

endmodule

// ===== src/bmp_stream_to_framebuffer_blit.sv =====
// Top level of the streaming 24-bit BMP framebuffer blit.
// A result word passes through a queue slot and then the output register after its byte is accepted.
// Throughput: one byte per cycle while the queue is not full, set by the counter update in the
// front end and the one-word-per-cycle write stage, which out_ready can stall; a two-entry queue decouples them.
// Reset is synchronous: counters and queue clear, registers return to 800x480 at (0,0).
`timescale 1ns / 1ps
`include "bmp_stream_to_framebuffer_blit_macros.svh"
module bmp_stream_to_framebuffer_blit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bsfb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       pixel_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             write_valid,
  output logic [18:0]                      write_index,
  output logic [23:0]                      pixel_color,
  output logic                             image_done
);
  import bsfb_pkg::*;

  queue_stat_t q_stat;
  entry_t      push_entry;
  entry_t      pop_entry;
  logic        push;
  logic        pop;

  bsfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_byte (pixel_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  bsfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .stat       (q_stat)
  );

  bsfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .pop_entry   (pop_entry),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .write_valid (write_valid),
    .write_index (write_index),
    .pixel_color (pixel_color),
    .image_done  (image_done)
  );

  `BSFB_ASSERT_NEXT(a_accept_queued, clk, rst, in_valid && in_ready, q_stat.count != 2'd0)
  `BSFB_ASSERT_IMP(a_stall_only_full, clk, rst, !in_ready, q_stat.count == 2'(QUEUE_DEPTH))
  `BSFB_ASSERT_IMP(a_index_on_screen, clk, rst, out_valid && write_valid, write_index < 19'(SCREEN_PIXELS))
  `BSFB_ASSERT_IMP(a_clipped_zero, clk, rst, out_valid && !write_valid, write_index == 19'd0)

endmodule

// ===== tb/bmp_stream_to_framebuffer_blit_tb.sv =====
// Self-checking testbench for the BMP pixel stream to framebuffer blit.
`timescale 1ns / 1ps
module bmp_stream_to_framebuffer_blit_tb;
  import bsfb_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd9;
  localparam int RANDOM_BYTES = 1650;

  typedef struct {
    logic        wvalid;
    logic [18:0] index;
    logic [23:0] color;
    logic        done;
  } fb_write_t;

  // Tracks the image geometry and byte position, and keeps the framebuffer
  // writes that are still owed by the block.
  class fb_write_tracker;
    bit [11:0]        img_w;
    bit [11:0]        img_h;
    bit signed [12:0] x_off;
    bit signed [12:0] y_off;
    bit [1:0]         phase;
    bit [1:0]         pad_left;
    bit [7:0]         blue;
    bit [7:0]         green;
    bit [11:0]        col;
    bit [11:0]        row;
    fb_write_t        expected_writes[$];
    int               fails;

    function new();
      img_w = SCREEN_WIDTH;
      img_h = SCREEN_HEIGHT;
      x_off = 0;
      y_off = 0;
      phase = 0;
      pad_left = 0;
      blue = 0;
      green = 0;
      col = 0;
      row = 0;
      fails = 0;
    endfunction

    function void set_reg(bit [CFG_INDEX_W-1:0] idx, bit [CFG_DATA_W-1:0] d);
      case (idx)
        REG_IMAGE_WIDTH: img_w = d[11:0];
        REG_IMAGE_HEIGHT: img_h = d[11:0];
        REG_X_OFFSET: x_off = d;
        REG_Y_OFFSET: y_off = d;
        default: ;
      endcase
    endfunction

    function void take_byte(bit [7:0] b);
      fb_write_t w;
      int sx;
      int sy;
      bit row_end;
      bit last_row;
      w = '{wvalid: 1'b0, index: '0, color: '0, done: 1'b0};
      if (pad_left != 0) begin
        pad_left = pad_left - 2'd1;
      end else if (phase == 2'd1) begin
        green = b;
        phase = 2'd2;
      end else if (phase == 2'd2) begin
        w.color = {b, green, blue};
        sx = int'(col) + int'(x_off);
        sy = int'(img_h) - 1 - int'(row) + int'(y_off);
        if (sx >= 0 && sx < SCREEN_WIDTH && sy >= 0 && sy < SCREEN_HEIGHT) begin
          w.wvalid = 1'b1;
          w.index = 19'(sy * SCREEN_WIDTH + sx);
        end
        row_end = int'(col) + 1 >= int'(img_w);
        last_row = int'(row) + 1 >= int'(img_h);
        if (row_end) begin
          col = 0;
          // Rows are padded out to a multiple of four bytes.
          pad_left = 2'(4 - ((int'(img_w) * 3) & 3));
          if (last_row) begin
            w.done = 1'b1;
            row = 0;
          end else begin
            row = row + 12'd1;
          end
        end else begin
          col = col + 12'd1;
        end
        phase = 2'd0;
      end else begin
        blue = b;
        phase = 2'd1;
      end
      expected_writes.push_back(w);
    endfunction

    function void match_write(logic wv, logic [18:0] idx, logic [23:0] c, logic d);
      fb_write_t exp;
      if (expected_writes.size() == 0) begin
        $error("unexpected word: write_valid %0d write_index %0d pixel_color %h image_done %0d",
               wv, idx, c, d);
        fails++;
        return;
      end
      exp = expected_writes.pop_front();
      if (wv !== exp.wvalid) begin
        $error("write_valid: expected %0d, got %0d", exp.wvalid, wv);
        fails++;
      end
      if (idx !== exp.index) begin
        $error("write_index: expected %0d, got %0d", exp.index, idx);
        fails++;
      end
      if (c !== exp.color) begin
        $error("pixel_color: expected %h, got %h", exp.color, c);
        fails++;
      end
      if (d !== exp.done) begin
        $error("image_done: expected %0d, got %0d", exp.done, d);
        fails++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             pixel_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic                   write_valid;
  logic [18:0]            write_index;
  logic [23:0]            pixel_color;
  logic                   image_done;

  fb_write_tracker tracker = new();
  int accepted_bytes = 0;
  bit no_idle = 1'b0;
  bit hold_start = 1'b0;
  bit hold_done = 1'b0;

  bmp_stream_to_framebuffer_blit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_byte(pixel_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .write_valid(write_valid),
    .write_index(write_index),
    .pixel_color(pixel_color),
    .image_done(image_done)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #6000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      tracker.take_byte(pixel_byte);
      accepted_bytes++;
    end
    if (!rst && out_valid && out_ready) begin
      tracker.match_write(write_valid, write_index, pixel_color, image_done);
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side: random back-pressure plus one long hold-off that lets the
  // block fill up and stall its byte input.
  initial begin
    int gap;
    int hold;
    gap = 0;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && hold_start) begin
        hold_done = 1'b1;
        hold = 120;
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (gap > 0) begin
        out_ready = 1'b0;
        gap--;
      end else begin
        out_ready = 1'b1;
        gap = idle_gap();
      end
    end
  end

  task automatic send_byte(input bit [7:0] b);
    @(negedge clk);
    in_valid = 1'b1;
    pixel_byte = b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap();
    int n;
    n = idle_gap();
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, CFG_DATA_W'(value));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (tracker.expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic send_bytes(input int n, input bit [7:0] b);
    for (int i = 0; i < n; i++) begin
      send_byte(b);
      sender_gap();
    end
    stop_sending();
    wait_idle();
  endtask

  function automatic int pick_offset(input int screen_size);
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 16)) - 8;
      1: return screen_size - 10 + int'($urandom_range(0, 15));
      2: return int'($urandom_range(0, screen_size - 1));
      default: return int'($urandom_range(0, 8191)) - 4096;
    endcase
  endfunction

  task automatic random_phase();
    int w;
    int h;
    int img_bytes;
    int n;
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      w = 4095;
      h = $urandom_range(1, 4095);
    end else if (pick == 1) begin
      w = $urandom_range(1, 6);
      h = 4095;
    end else begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 5);
    end
    if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, w);
    if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, h);
    if ($urandom_range(0, 3) != 0) write_reg(REG_X_OFFSET, pick_offset(SCREEN_WIDTH));
    if ($urandom_range(0, 3) != 0) write_reg(REG_Y_OFFSET, pick_offset(SCREEN_HEIGHT));
    if ($urandom_range(0, 9) == 0) write_reg(REG_UNMAPPED, $urandom_range(0, 8191));

    img_bytes = int'(tracker.img_h)
              * (int'(tracker.img_w) * 3 + ((4 - ((int'(tracker.img_w) * 3) & 3)) & 3));
    // Mostly whole images; now and then a phase stops part way through a row
    // so that the next geometry change lands mid-image.
    if (img_bytes > 0 && img_bytes <= 150 && $urandom_range(0, 3) != 0)
      n = img_bytes * int'($urandom_range(1, 150 / img_bytes));
    else
      n = $urandom_range(5, 60);

    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      send_byte($urandom_range(0, 255));
      sender_gap();
    end
    stop_sending();
    wait_idle();
  endtask

  initial begin
    int start_count;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel_byte = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset geometry: a black and a white pixel on the bottom screen row.
    send_bytes(3, 8'h00);
    send_bytes(3, 8'hFF);

    // One-pixel image at the far screen corner, entered mid-row.
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_X_OFFSET, SCREEN_WIDTH - 1);
    write_reg(REG_Y_OFFSET, SCREEN_HEIGHT - 1);
    send_bytes(8, 8'hFF);

    // Width and height of zero (width write wraps to zero), offsets at the minimum.
    write_reg(REG_IMAGE_WIDTH, 4096);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_X_OFFSET, -4096);
    write_reg(REG_Y_OFFSET, -4096);
    send_bytes(6, 8'hA5);

    // Largest geometry and offsets; a write to an unmapped index changes nothing.
    write_reg(REG_IMAGE_WIDTH, 4095);
    write_reg(REG_IMAGE_HEIGHT, 4095);
    write_reg(REG_X_OFFSET, 4095);
    write_reg(REG_Y_OFFSET, 4095);
    write_reg(REG_UNMAPPED, 5);
    send_bytes(3, 8'h5A);

    // Bytes keep coming while the result side holds off, so the block fills up.
    no_idle = 1'b1;
    hold_start = 1'b1;
    send_bytes(60, 8'h3C);

    start_count = accepted_bytes;
    while (accepted_bytes - start_count < RANDOM_BYTES) random_phase();

    wait_idle();
    repeat (4) @(posedge clk);
    if (tracker.expected_writes.size() != 0) begin
      $error("%0d expected words never arrived", tracker.expected_writes.size());
      tracker.fails++;
    end
    if (tracker.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
